// ===== design/ip_country_trie_lookup_assert.svh =====
// Assertion macros used by the trie lookup back end (ipct_back). Clock clk, reset rst_n.
`ifndef IP_COUNTRY_TRIE_LOOKUP_ASSERT_SVH
`define IP_COUNTRY_TRIE_LOOKUP_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define IPCT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define IPCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ipct_pkg.sv =====
package ipct_pkg;

  typedef struct packed {
    logic        kind;
    logic [17:0] node_index;
    logic [23:0] left_record;
    logic [23:0] right_record;
    logic [31:0] ip_address;
  } ipct_in_t;

  typedef struct packed {
    logic [7:0] country_index;
    logic [2:0] lookup_status;
  } ipct_out_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_WALK,
    OP_INACTIVE
  } ipct_op_t;

  typedef struct packed {
    ipct_op_t    op;
    logic [17:0] node_index;
    logic [23:0] left_record;
    logic [23:0] right_record;
    logic [31:0] ip_address;
  } ipct_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } ipct_back_state_t;

  localparam logic       KIND_LOAD = 1'b0;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_INACTIVE = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOLEAF   = 3'd3;
  localparam logic [2:0] ST_BADPTR   = 3'd4;

  localparam logic [23:0] LEAF_BASE  = 24'd16776960;
  localparam logic [7:0]  CODE_LIMIT = 8'd255;
  localparam logic [4:0]  TOP_LEVEL  = 5'd31;

  localparam int          Q_DEPTH = 4;
  localparam int          Q_AW    = 2;

endpackage

// ===== design/ipct_front.sv =====
module ipct_front #(
  parameter int NODE_COUNT = 262144
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ipct_pkg::ipct_in_t   in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output ipct_pkg::ipct_cmd_t  q_cmd
);
  import ipct_pkg::*;

  logic enable_r;
  logic accept;
  logic slot_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign slot_ok   = {14'd0, in_data.node_index} < 32'(NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  // Loads beyond the store are accepted and dropped here.
  always_comb begin
    q_cmd.node_index   = in_data.node_index;
    q_cmd.left_record  = in_data.left_record;
    q_cmd.right_record = in_data.right_record;
    q_cmd.ip_address   = in_data.ip_address;
    q_cmd.op           = OP_WALK;
    q_push             = accept;
    if (in_data.kind == KIND_LOAD) begin
      q_cmd.op = OP_LOAD;
      q_push   = accept && slot_ok;
    end else if (!enable_r) begin
      q_cmd.op = OP_INACTIVE;
    end
  end

endmodule

// ===== design/ipct_queue.sv =====
module ipct_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ipct_pkg::ipct_cmd_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output ipct_pkg::ipct_cmd_t  pop_data
);
  import ipct_pkg::*;

  ipct_cmd_t        slot_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = count_r == (Q_AW+1)'(Q_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/ipct_back.sv =====
`include "ip_country_trie_lookup_assert.svh"

module ipct_back #(
  parameter int NODE_COUNT = 262144
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ipct_pkg::ipct_cmd_t  q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ipct_pkg::ipct_out_t  out_data
);
  import ipct_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  ipct_back_state_t state_r, state_nxt;
  logic [4:0]       level_r, level_nxt;
  logic [31:0]      ip_r, ip_nxt;
  ipct_out_t        res_r, res_nxt;
  logic             out_valid_r;
  ipct_out_t        out_data_r;

  logic [47:0]      node_mem [NODE_COUNT];
  logic [47:0]      rd_data_r;
  logic             rd_en, wr_en, out_load, out_free;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [23:0]      wr_slot;
  logic [23:0]      rec;
  logic             is_leaf, ptr_ok;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign rec     = ip_r[level_r] ? rd_data_r[47:24] : rd_data_r[23:0];
  assign is_leaf = rec >= LEAF_BASE;
  assign ptr_ok  = {8'd0, rec} < 32'(NODE_COUNT);
  assign wr_slot = {6'd0, q_cmd.node_index};
  assign wr_addr = wr_slot[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    ip_nxt    = ip_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_LOAD: begin
              wr_en = 1'b1;
            end
            OP_WALK: begin
              rd_en     = 1'b1;
              ip_nxt    = q_cmd.ip_address;
              level_nxt = TOP_LEVEL;
              state_nxt = BK_WALK;
            end
            default: begin
              res_nxt   = '{country_index: 8'd0, lookup_status: ST_INACTIVE};
              state_nxt = BK_DONE;
            end
          endcase
        end
      end
      BK_WALK: begin
        // rd_data_r holds the node read for level_r
        if (is_leaf) begin
          if (rec[7:0] == CODE_LIMIT) begin
            res_nxt = '{country_index: 8'd0, lookup_status: ST_RANGE};
          end else begin
            res_nxt = '{country_index: rec[7:0], lookup_status: ST_FOUND};
          end
          state_nxt = BK_DONE;
        end else if (!ptr_ok) begin
          res_nxt   = '{country_index: 8'd0, lookup_status: ST_BADPTR};
          state_nxt = BK_DONE;
        end else if (level_r == '0) begin
          res_nxt   = '{country_index: 8'd0, lookup_status: ST_NOLEAF};
          state_nxt = BK_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = rec[AW-1:0];
          level_nxt = level_r - 1'b1;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    ip_r    <= ip_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= {q_cmd.right_record, q_cmd.left_record};
    end
    if (rd_en) begin
      rd_data_r <= node_mem[rd_addr];
    end
  end

  `IPCT_ASSERT(a_pop_only_idle, !q_pop || state_r == BK_IDLE, "queue popped while busy")
  `IPCT_ASSERT(a_no_rw_clash, !(wr_en && rd_en), "node write and read in same cycle")
  `IPCT_ASSERT_NEXT(a_done_holds, state_r == BK_DONE && !out_free, state_r == BK_DONE, "pending result dropped")
  `IPCT_ASSERT_NEXT(a_walk_descends, state_r == BK_WALK && state_nxt == BK_WALK, level_r == $past(level_r) - 5'd1, "walk level did not step")

endmodule

// ===== design/ip_country_trie_lookup.sv =====
// IPv4 country lookup over a binary trie held in an on-chip node memory.
// The front accepts items, drops loads beyond the store and tags lookups as
// inactive when the enable set through cfg_data is 0; a four-entry queue hands
// them to the back, which runs them in order. A load is written to the node
// memory as the back pops it. A lookup reads one node per trie level visited,
// 1 to 32 levels: one node memory read per level is the limiting loop. An
// inactive lookup goes straight to the result. The result register frees the
// walker as soon as a result is handed over. Nodes read before they are loaded
// give undefined results; there is no clearing pass after reset. Configuration
// is taken at any time through cfg_valid/cfg_ready.
module ip_country_trie_lookup #(
  parameter int NODE_COUNT = 262144
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ipct_pkg::ipct_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ipct_pkg::ipct_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import ipct_pkg::*;

  logic      q_full, q_push, q_pop, q_valid;
  ipct_cmd_t q_in, q_out;

  ipct_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  ipct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  ipct_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
